[hdl/t2i_pkg.sv]
package t2i_pkg;

   // Result status codes
   localparam logic [2:0] ST_OK     = 3'd0;
   localparam logic [2:0] ST_EMPTY  = 3'd1;
   localparam logic [2:0] ST_NODIG  = 3'd2;
   localparam logic [2:0] ST_BADDIG = 3'd3;
   localparam logic [2:0] ST_EXCEED = 3'd4;

   // Character codes
   localparam logic [7:0] CHAR_NUL     = 8'h00;
   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_CR      = 8'h0D;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_B = 8'h62;
   localparam logic [7:0] CHAR_LOWER_F = 8'h66;
   localparam logic [7:0] CHAR_LOWER_X = 8'h78;
   localparam logic [7:0] CASE_BIT     = 8'h20;

   localparam int unsigned ACC_W = 128;

   typedef enum logic [1:0] {
      RADIX_2,
      RADIX_8,
      RADIX_10,
      RADIX_16
   } radix_type;

   typedef struct packed {
      logic [2:0]       err;
      logic [ACC_W-1:0] acc;
   } mac_result_type;

endpackage

[hdl/t2i_mac.sv]
// Digit decode and accumulate: acc * radix + digit, wrapping at 128 bits.
module t2i_mac
   import t2i_pkg::*;
(
   input  logic [7:0]       char_code,
   input  radix_type        radix,
   input  logic [ACC_W-1:0] acc,
   output mac_result_type   res
);

   logic [7:0]       lc;
   logic [3:0]       digit;
   logic             is_dec;
   logic             is_hex;
   logic             exceed;
   logic [ACC_W-1:0] scaled;

   always_comb begin
      lc = (char_code inside {[CHAR_UPPER_A:CHAR_UPPER_Z]}) ? (char_code | CASE_BIT) : char_code;
      is_dec = lc inside {[CHAR_ZERO:CHAR_NINE]};
      is_hex = (radix == RADIX_16) && (lc inside {[CHAR_LOWER_A:CHAR_LOWER_F]});
      digit  = is_dec ? lc[3:0] : 4'(lc[3:0] + 4'd9);
      exceed = ((radix == RADIX_2) && (digit > 4'd1)) ||
               ((radix == RADIX_8) && (digit > 4'd7));

      case (radix)
         RADIX_2:  scaled = {acc[ACC_W-2:0], 1'b0};
         RADIX_8:  scaled = {acc[ACC_W-4:0], 3'b000};
         RADIX_16: scaled = {acc[ACC_W-5:0], 4'b0000};
         default:  scaled = {acc[ACC_W-4:0], 3'b000} + {acc[ACC_W-2:0], 1'b0};
      endcase

      res.acc = scaled + {{(ACC_W-4){1'b0}}, digit};
      if (!is_dec && !is_hex) begin
         res.err = ST_BADDIG;
      end else if (exceed) begin
         res.err = ST_EXCEED;
      end else begin
         res.err = ST_OK;
      end
   end

endmodule

[hdl/text_to_int128_parser.sv]
// Streaming text to 128-bit integer parser. Feed one character word per cycle on req_;
// a zero word ends the string. Leading whitespace (tab..carriage return, space) is skipped,
// one '+' or '-' is taken, then the base is chosen: "0x"/"0X" hex, "0b"/"0B" binary, a '0'
// followed by a decimal digit octal, anything else decimal. Digits accumulate modulo 2^128
// and '-' gives the two's complement. Only the terminator produces a result word: status
// (0 ok, 1 empty, 2 no digits, 3 invalid digit, 4 digit exceeds base) and the value split
// into two 64-bit halves, zero whenever status is not ok. The first error is held and the
// rest of the string ignored. After the terminator the parser is back in its reset state.
// Rate: one character per cycle while req_stall is low. Each word passes an input register
// and then the state update; the terminator's result is registered in the result register,
// which drives rsp_valid. The cycle is set by the 128-bit multiply-by-radix-and-add (shifts
// and one three-input add). While a result waits on rsp_stall, further characters are still
// taken; only a following terminator holds in the input register and raises req_stall.
module text_to_int128_parser
   import t2i_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_char_code,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [63:0] rsp_value_low,
   output logic [63:0] rsp_value_high
);

   typedef enum logic [2:0] {
      PH_START,
      PH_SPACE,
      PH_SIGNED,
      PH_ZERO,
      PH_PREFIX,
      PH_DIGITS
   } phase_type;

   // Input register
   logic             in_valid_ff, in_valid_in;
   logic [7:0]       char_ff;

   // Parser state
   phase_type        phase_ff, phase_in;
   radix_type        radix_ff, radix_in;
   logic             neg_ff, neg_in;
   logic [ACC_W-1:0] acc_ff, acc_in;
   logic [2:0]       err_ff, err_in;

   // Result register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [2:0]       status_ff, status_in;
   logic [ACC_W-1:0] value_ff, value_in;

   logic             is_term;
   logic             is_space;
   logic             is_dec;
   logic             is_sign;
   logic             out_free;
   logic             emit;
   logic             take;
   radix_type        mac_radix;
   mac_result_type   mac_res;

   assign is_term  = (char_ff == CHAR_NUL);
   assign is_space = (char_ff == CHAR_SPACE) || (char_ff inside {[CHAR_TAB:CHAR_CR]});
   assign is_dec   = char_ff inside {[CHAR_ZERO:CHAR_NINE]};
   assign is_sign  = (char_ff == CHAR_PLUS) || (char_ff == CHAR_MINUS);

   // The result register is free when empty or being drained this cycle
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign emit      = in_valid_ff && is_term && out_free;
   // Hold only a terminator that cannot yet reach the result register
   assign req_stall = in_valid_ff && is_term && !out_free;
   assign take      = req_valid && !req_stall;

   assign in_valid_in = req_stall ? in_valid_ff : req_valid;

   // A digit after a leading zero fixes the base here: octal for a decimal digit
   always_comb begin
      case (phase_ff)
         PH_ZERO:             mac_radix = is_dec ? RADIX_8 : RADIX_10;
         PH_PREFIX, PH_DIGITS: mac_radix = radix_ff;
         default:             mac_radix = RADIX_10;
      endcase
   end

   t2i_mac u_mac (
      .char_code (char_ff),
      .radix     (mac_radix),
      .acc       (acc_ff),
      .res       (mac_res)
   );

   always_comb begin
      phase_in  = phase_ff;
      radix_in  = radix_ff;
      neg_in    = neg_ff;
      acc_in    = acc_ff;
      err_in    = err_ff;
      status_in = status_ff;
      value_in  = value_ff;

      if (emit) begin
         // Settle the status, then drop back to the reset state
         if (err_ff != ST_OK) begin
            status_in = err_ff;
         end else begin
            case (phase_ff)
               PH_START:          status_in = ST_EMPTY;
               PH_ZERO, PH_DIGITS: status_in = ST_OK;
               default:           status_in = ST_NODIG;
            endcase
         end
         if (status_in != ST_OK) begin
            value_in = '0;
         end else if (neg_ff) begin
            value_in = ~acc_ff + {{(ACC_W-1){1'b0}}, 1'b1};
         end else begin
            value_in = acc_ff;
         end
         phase_in = PH_START;
         radix_in = RADIX_10;
         neg_in   = 1'b0;
         acc_in   = '0;
         err_in   = ST_OK;
      end else if (in_valid_ff && !is_term && (err_ff == ST_OK)) begin
         case (phase_ff)
            PH_START, PH_SPACE, PH_SIGNED: begin
               if (phase_ff != PH_SIGNED && is_space) begin
                  phase_in = PH_SPACE;
               end else if (phase_ff != PH_SIGNED && is_sign) begin
                  neg_in   = (char_ff == CHAR_MINUS);
                  phase_in = PH_SIGNED;
               end else if (char_ff == CHAR_ZERO) begin
                  phase_in = PH_ZERO;
               end else begin
                  radix_in = RADIX_10;
                  phase_in = PH_DIGITS;
               end
            end
            PH_ZERO: begin
               if ((char_ff | CASE_BIT) == CHAR_LOWER_X) begin
                  radix_in = RADIX_16;
                  phase_in = PH_PREFIX;
               end else if ((char_ff | CASE_BIT) == CHAR_LOWER_B) begin
                  radix_in = RADIX_2;
                  phase_in = PH_PREFIX;
               end else begin
                  radix_in = mac_radix;
                  phase_in = PH_DIGITS;
               end
            end
            default: begin
               phase_in = PH_DIGITS;
            end
         endcase

         // Accumulate or latch the first error when this word goes to the digit phase
         if (phase_in == PH_DIGITS) begin
            if (mac_res.err != ST_OK) begin
               err_in = mac_res.err;
            end else begin
               acc_in = mac_res.acc;
            end
         end
      end
   end

   assign rsp_valid_in = emit || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         phase_ff     <= PH_START;
         radix_ff     <= RADIX_10;
         neg_ff       <= 1'b0;
         acc_ff       <= '0;
         err_ff       <= ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         phase_ff     <= phase_in;
         radix_ff     <= radix_in;
         neg_ff       <= neg_in;
         acc_ff       <= acc_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers: load on take / emit, otherwise hold
   always_ff @(posedge clock) begin
      if (take) begin
         char_ff <= req_char_code;
      end
      status_ff <= status_in;
      value_ff  <= value_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_value_low  = value_ff[63:0];
   assign rsp_value_high = value_ff[ACC_W-1:64];

endmodule

[hdl/t2i_checker.sv]
module t2i_checker
   import t2i_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [7:0]  req_char_code,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [2:0]  rsp_status,
   input logic [63:0] rsp_value_low,
   input logic [63:0] rsp_value_high
);

   // An error result carries a zero value
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |-> (rsp_value_low == 64'd0) && (rsp_value_high == 64'd0))
      else $error("error result with non-zero value");

   // Input back-pressure only while a result word is held by the consumer
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("req_stall without a blocked result");

   // Nothing is presented right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) &&
         $stable(rsp_value_low) && $stable(rsp_value_high))
      else $error("stalled result changed");

   // A stalled character word holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_char_code))
      else $error("stalled character changed");

endmodule

bind text_to_int128_parser t2i_checker u_t2i_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .req_char_code  (req_char_code),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_status     (rsp_status),
   .rsp_value_low  (rsp_value_low),
   .rsp_value_high (rsp_value_high)
);
